// ----- rtl/mlpt_pkg.sv -----
// Shared types, codes and arithmetic helpers for the two-layer perceptron trainer.
package mlpt_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_HIDDEN  = 16;
  localparam int MAX_OUTPUTS = 16;
  localparam int SIG_DEPTH   = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_DEPTH);

  localparam int VAL_W  = 16;
  localparam int ACT_W  = 13;
  localparam int LR_W   = 12;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 4;
  localparam int OPW    = VAL_W + 1;
  localparam int PROD_W = 2 * OPW;
  localparam int ACC_W  = 2 * VAL_W + $clog2(MAX_INPUTS) + 1;

  localparam logic [ACT_W-1:0] ONE_Q12 = ACT_W'(4096);

  // configuration register indexes
  localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_HIDDEN_COUNT = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd2;
  localparam logic [1:0] CFG_LEARN_RATE   = 2'd3;

  localparam logic RES_QUERY = 1'b0;
  localparam logic RES_DONE  = 1'b1;

  typedef enum logic [2:0] {
    REQ_LOAD_INPUT   = 3'd0,
    REQ_LOAD_TARGET  = 3'd1,
    REQ_QUERY        = 3'd2,
    REQ_TRAIN        = 3'd3,
    REQ_WRITE_WEIGHT = 3'd4
  } req_kind_t;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic                    layer_sel;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             result_kind;
    logic [IDX_W-1:0] node_index;
    logic [ACT_W-1:0] activation;
    logic             last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FWD_H, S_FWD_O, S_EMIT, S_ERR_O, S_BP_H,
    S_GRAD_O, S_UPD_O, S_GRAD_H, S_UPD_H, S_DONE
  } state_t;

  // last index in use for a count register: zero acts as one, capped at 16
  function automatic logic [IDX_W-1:0] last_idx(input logic [CNT_W-1:0] n);
    logic [IDX_W-1:0] r;
    if (n == '0) r = '0;
    else if (n > CNT_W'(16)) r = '1;
    else r = IDX_W'(n - CNT_W'(1));
    return r;
  endfunction

  // round 24 fraction bits to 12 (half up, floor), saturate to 16 bits
  function automatic logic signed [VAL_W-1:0] rsat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] q;
    logic signed [VAL_W-1:0] o;
    r = v + signed'(ACC_W'(2048));
    q = r >>> 12;
    if (q > signed'(ACC_W'(32767))) o = 16'sh7FFF;
    else if (q < -signed'(ACC_W'(32768))) o = 16'sh8000;
    else o = VAL_W'(q);
    return o;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [VAL_W:0] v);
    logic signed [VAL_W-1:0] o;
    if (v > 17'sd32767) o = 16'sh7FFF;
    else if (v < -17'sd32768) o = 16'sh8000;
    else o = VAL_W'(v);
    return o;
  endfunction

  // unsigned quotient by shift and subtract, used only to build the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-t) in Q30: Taylor series of exp(-t/16), squared four times
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    u    = t << 14;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * u) >> 30, 64'(k));
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    for (int k = 0; k < 4; k++) sum = (sum * sum + (64'd1 << 29)) >> 30;
    return sum;
  endfunction

  function automatic logic [ACT_W-1:0] sig_entry(input int k);
    longint      c;
    logic [63:0] t;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    c   = -32768 + (((2 * longint'(k) + 1) * 32768) >>> SIG_IDX_W);
    t   = (c < 0) ? 64'(-c) : 64'(c);
    e   = exp_neg_q30(t);
    den = (64'd1 << 30) + e;
    num = (c < 0) ? 64'd4096 * e : (64'd4096 << 30);
    return ACT_W'(udiv64(num + (den >> 1), den));
  endfunction

  function automatic logic [SIG_DEPTH*ACT_W-1:0] sig_rom_build();
    logic [SIG_DEPTH*ACT_W-1:0] r;
    r = '0;
    for (int k = 0; k < SIG_DEPTH; k++) r[k*ACT_W +: ACT_W] = sig_entry(k);
    return r;
  endfunction

  localparam logic [SIG_DEPTH*ACT_W-1:0] SIG_ROM = sig_rom_build();

endpackage

// ----- rtl/mlpt_sigmoid.sv -----
// Logistic activation by table lookup over the Q4.12 range.
module mlpt_sigmoid (
  input  logic signed [mlpt_pkg::VAL_W-1:0] sum,
  output logic        [mlpt_pkg::ACT_W-1:0] act
);
  import mlpt_pkg::*;

  logic [VAL_W-1:0]     biased;
  logic [SIG_IDX_W-1:0] idx;

  // (sum + 32768) * depth >> 16 is the top bits of the offset-binary sum
  assign biased = VAL_W'(sum) ^ {1'b1, {(VAL_W-1){1'b0}}};
  assign idx    = biased[VAL_W-1 -: SIG_IDX_W];
  assign act    = SIG_ROM[idx*ACT_W +: ACT_W];

endmodule

// ----- rtl/mlp_two_layer_sigmoid_trainer_core.sv -----
// Top level: two-layer sigmoid perceptron, query and on-line backprop training.
//
// Requests load input or target elements, write one weight, or start a query
// or a training step; loads and weight writes take effect when accepted. Query
// and train run on one shared 17x17 multiplier under a sequencer, each multiply
// stepping through weight memory read, multiply, and accumulate or write back.
// A query returns one result per output node, the last one marked. A training
// step returns one done result. in_ready is high only between requests; a
// result may still wait in the output register while the next request is
// taken. The user must write configuration only while the block is idle; the
// block itself does not enforce it.
module mlp_two_layer_sigmoid_trainer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [mlpt_pkg::LR_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mlpt_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mlpt_pkg::rsp_t                out_data
);
  import mlpt_pkg::*;

  localparam logic [1:0] PH_ADDR = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_ACC  = 2'd2;
  localparam int         WA_W    = 2 * IDX_W;

  state_t state, state_next;

  logic [CNT_W-1:0] input_count, hidden_count, output_count;
  logic [LR_W-1:0]  learning_rate;
  logic [IDX_W-1:0] li_in, li_hid, li_out;

  logic signed [VAL_W-1:0] input_vector  [MAX_INPUTS];
  logic signed [VAL_W-1:0] target_vector [MAX_OUTPUTS];
  logic        [ACT_W-1:0] hidden_act    [MAX_HIDDEN];
  logic        [ACT_W-1:0] output_act    [MAX_OUTPUTS];
  logic signed [VAL_W-1:0] output_error  [MAX_OUTPUTS];
  logic signed [VAL_W-1:0] hidden_error  [MAX_HIDDEN];

  logic signed [VAL_W-1:0] w1_mem [MAX_HIDDEN*MAX_INPUTS];
  logic signed [VAL_W-1:0] w2_mem [MAX_OUTPUTS*MAX_HIDDEN];
  logic signed [VAL_W-1:0] w1_q, w2_q, w1_wdata, w2_wdata;
  logic [WA_W-1:0]         w1_raddr, w2_raddr, w1_waddr, w2_waddr;
  logic                    w1_we, w2_we;

  logic [1:0]              ph, gs;
  logic [IDX_W-1:0]        ci, ch, co;
  logic                    is_train;
  logic signed [ACC_W-1:0] acc, acc_sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [OPW-1:0]   mul_a, mul_b;
  logic signed [VAL_W-1:0] g, acc_rnd, prod_rnd, upd_w;
  logic signed [VAL_W-1:0] grad_err;
  logic        [ACT_W-1:0] grad_act, sig_act;
  logic                    slot_free, accept, start, grad_end, emit;

  assign li_in     = last_idx(input_count);
  assign li_hid    = last_idx(hidden_count);
  assign li_out    = last_idx(output_count);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign start     = accept && (in_data.req_type == REQ_QUERY ||
                                in_data.req_type == REQ_TRAIN);
  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == S_EMIT || state == S_DONE) && slot_free;
  assign grad_end  = (ph == PH_ACC) && (gs == 2'd2);

  assign acc_sum  = acc + ACC_W'(prod);
  assign acc_rnd  = rsat(acc_sum);
  assign prod_rnd = rsat(ACC_W'(prod));

  mlpt_sigmoid u_sig (
    .sum (acc_rnd),
    .act (sig_act)
  );

  // operand selection for the shared multiplier
  always_comb begin
    grad_err = (state == S_GRAD_O) ? output_error[co] : hidden_error[ch];
    grad_act = (state == S_GRAD_O) ? output_act[co]   : hidden_act[ch];
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_FWD_H: begin
        mul_a = OPW'(w1_q);
        mul_b = OPW'(input_vector[ci]);
      end
      S_FWD_O: begin
        mul_a = OPW'(w2_q);
        mul_b = signed'({{(OPW-ACT_W){1'b0}}, hidden_act[ch]});
      end
      S_BP_H: begin
        mul_a = OPW'(w2_q);
        mul_b = OPW'(output_error[co]);
      end
      S_GRAD_O, S_GRAD_H: begin
        case (gs)
          2'd0: begin
            mul_a = OPW'(grad_err);
            mul_b = signed'({{(OPW-ACT_W){1'b0}}, grad_act});
          end
          2'd1: begin
            mul_a = OPW'(g);
            mul_b = signed'({{(OPW-ACT_W){1'b0}}, ONE_Q12 - grad_act});
          end
          default: begin
            mul_a = OPW'(g);
            mul_b = signed'({{(OPW-LR_W){1'b0}}, learning_rate});
          end
        endcase
      end
      S_UPD_O: begin
        mul_a = OPW'(g);
        mul_b = signed'({{(OPW-ACT_W){1'b0}}, hidden_act[ch]});
      end
      S_UPD_H: begin
        mul_a = OPW'(g);
        mul_b = OPW'(input_vector[ci]);
      end
      default: ;
    endcase
  end

  // weight memories: one read and one write port each
  always_comb begin
    w1_raddr = {ch, ci};
    w2_raddr = {co, ch};
    upd_w    = sat16(VAL_W'(0) + ((state == S_UPD_H) ?
                 ({w1_q[VAL_W-1], w1_q} + {prod_rnd[VAL_W-1], prod_rnd}) :
                 ({w2_q[VAL_W-1], w2_q} + {prod_rnd[VAL_W-1], prod_rnd})));
    w1_we    = 1'b0;
    w2_we    = 1'b0;
    w1_waddr = {in_data.row_index, in_data.col_index};
    w2_waddr = {in_data.row_index, in_data.col_index};
    w1_wdata = in_data.value;
    w2_wdata = in_data.value;
    if (accept && in_data.req_type == REQ_WRITE_WEIGHT) begin
      w1_we = !in_data.layer_sel;
      w2_we = in_data.layer_sel;
    end else if (state == S_UPD_H && ph == PH_ACC) begin
      w1_we    = 1'b1;
      w1_waddr = w1_raddr;
      w1_wdata = upd_w;
    end else if (state == S_UPD_O && ph == PH_ACC) begin
      w2_we    = 1'b1;
      w2_waddr = w2_raddr;
      w2_wdata = upd_w;
    end
  end

  always_ff @(posedge clk) begin
    if (w1_we) w1_mem[w1_waddr] <= w1_wdata;
    if (w2_we) w2_mem[w2_waddr] <= w2_wdata;
    w1_q <= w1_mem[w1_raddr];
    w2_q <= w2_mem[w2_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_FWD_H;
      S_FWD_H:  if (ph == PH_ACC && ci == li_in && ch == li_hid) state_next = S_FWD_O;
      S_FWD_O: begin
        if (ph == PH_ACC && ch == li_hid && co == li_out)
          state_next = is_train ? S_ERR_O : S_EMIT;
      end
      S_EMIT:   if (slot_free && co == li_out) state_next = S_IDLE;
      S_ERR_O:  if (co == li_out) state_next = S_BP_H;
      S_BP_H:   if (ph == PH_ACC && co == li_out && ch == li_hid) state_next = S_GRAD_O;
      S_GRAD_O: if (grad_end) state_next = S_UPD_O;
      S_UPD_O: begin
        if (ph == PH_ACC && ch == li_hid)
          state_next = (co == li_out) ? S_GRAD_H : S_GRAD_O;
      end
      S_GRAD_H: if (grad_end) state_next = S_UPD_H;
      S_UPD_H: begin
        if (ph == PH_ACC && ci == li_in)
          state_next = (ch == li_hid) ? S_DONE : S_GRAD_H;
      end
      S_DONE:   if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // shared unit: product registered every cycle
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count   <= CNT_W'(16);
      hidden_count  <= CNT_W'(16);
      output_count  <= CNT_W'(16);
      learning_rate <= LR_W'(1229);
      out_valid     <= 1'b0;
      ph            <= PH_ADDR;
      gs            <= 2'd0;
      ci            <= '0;
      ch            <= '0;
      co            <= '0;
      is_train      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_INPUT_COUNT:  input_count   <= cfg_data[CNT_W-1:0];
          CFG_HIDDEN_COUNT: hidden_count  <= cfg_data[CNT_W-1:0];
          CFG_OUTPUT_COUNT: output_count  <= cfg_data[CNT_W-1:0];
          CFG_LEARN_RATE:   learning_rate <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && !emit) out_valid <= 1'b0;

      if (state == S_FWD_H || state == S_FWD_O || state == S_BP_H ||
          state == S_GRAD_O || state == S_UPD_O || state == S_GRAD_H ||
          state == S_UPD_H)
        ph <= (ph == PH_ACC) ? PH_ADDR : ph + 2'd1;

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.req_type)
              REQ_LOAD_INPUT:  input_vector[in_data.row_index]  <= in_data.value;
              REQ_LOAD_TARGET: target_vector[in_data.row_index] <= in_data.value;
              REQ_QUERY, REQ_TRAIN: begin
                is_train <= (in_data.req_type == REQ_TRAIN);
                ph       <= PH_ADDR;
                gs       <= 2'd0;
                ci       <= '0;
                ch       <= '0;
                co       <= '0;
                acc      <= '0;
              end
              default: ;
            endcase
          end
        end
        S_FWD_H: begin
          if (ph == PH_ACC) begin
            if (ci == li_in) begin
              hidden_act[ch] <= sig_act;
              acc <= '0;
              ci  <= '0;
              ch  <= (ch == li_hid) ? '0 : ch + 1'b1;
            end else begin
              acc <= acc_sum;
              ci  <= ci + 1'b1;
            end
          end
        end
        S_FWD_O: begin
          if (ph == PH_ACC) begin
            if (ch == li_hid) begin
              output_act[co] <= sig_act;
              acc <= '0;
              ch  <= '0;
              co  <= (co == li_out) ? '0 : co + 1'b1;
            end else begin
              acc <= acc_sum;
              ch  <= ch + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid            <= 1'b1;
            out_data.result_kind <= RES_QUERY;
            out_data.node_index  <= co;
            out_data.activation  <= output_act[co];
            out_data.last        <= (co == li_out);
            co                   <= co + 1'b1;
          end
        end
        S_ERR_O: begin
          output_error[co] <= sat16({target_vector[co][VAL_W-1], target_vector[co]}
                                    - signed'({4'b0, output_act[co]}));
          co <= (co == li_out) ? '0 : co + 1'b1;
          if (co == li_out) begin
            ph  <= PH_ADDR;
            acc <= '0;
            ch  <= '0;
          end
        end
        S_BP_H: begin
          if (ph == PH_ACC) begin
            if (co == li_out) begin
              hidden_error[ch] <= acc_rnd;
              acc <= '0;
              co  <= '0;
              ch  <= (ch == li_hid) ? '0 : ch + 1'b1;
            end else begin
              acc <= acc_sum;
              co  <= co + 1'b1;
            end
          end
        end
        S_GRAD_O, S_GRAD_H: begin
          if (ph == PH_ACC) begin
            g  <= prod_rnd;
            gs <= (gs == 2'd2) ? 2'd0 : gs + 2'd1;
          end
        end
        S_UPD_O: begin
          if (ph == PH_ACC) begin
            if (ch == li_hid) begin
              ch <= '0;
              co <= (co == li_out) ? '0 : co + 1'b1;
            end else begin
              ch <= ch + 1'b1;
            end
          end
        end
        S_UPD_H: begin
          if (ph == PH_ACC) begin
            if (ci == li_in) begin
              ci <= '0;
              ch <= (ch == li_hid) ? '0 : ch + 1'b1;
            end else begin
              ci <= ci + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid            <= 1'b1;
            out_data.result_kind <= RES_DONE;
            out_data.node_index  <= '0;
            out_data.activation  <= '0;
            out_data.last        <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
